/* sv/tsc_pkg.sv */
// Shared constants of the triangle shape-function coefficient block.
// Used by the top level and by its port checker; depends on nothing.
package tsc_pkg;

  localparam int unsigned NumCorner = 3;
  localparam int unsigned NumCoord  = 2 * NumCorner;
  localparam int unsigned NumQuot   = 3 * NumCorner;

endpackage

/* sv/triangle_shape_coeffs.sv */
// Top level of the triangle shape-function coefficient pipeline.
// Depends on tsc_pkg for the corner and quotient counts.

// One triangle enters per clock unless an m_axis_tready stall reaches the input;
// its nine coefficients, Q16.16 at the default width, leave the last stage. Four stages
// form the differences, the cross products, twice the area and the operand
// magnitudes; one stage checks for quotient overflow; OUT_WIDTH stages each
// settle one quotient bit in nine parallel restoring dividers; a last stage
// saturates, restores the sign and holds the output word. Each stage moves
// on whenever the stage after it is empty or moving, so bubbles close up
// while the output word waits on m_axis_tready.
module triangle_shape_coeffs #(
  parameter int COORD_WIDTH = 24,
  parameter int OUT_WIDTH   = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // x1, y1, x2, y2, x3, y3 from the lowest bit up, zero padded to bytes.
  input  logic [((6*COORD_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  input  logic s_axis_tlast,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // a_one, b_one, c_one, a_two, b_two, c_two, a_three, b_three, c_three
  // from the lowest bit up, zero padded to bytes.
  output logic [((9*OUT_WIDTH+7)/8)*8-1:0] m_axis_tdata,
  // degenerate.
  output logic m_axis_tuser,
  output logic m_axis_tlast
);

  localparam int CW    = COORD_WIDTH;
  localparam int OW    = OUT_WIDTH;
  localparam int CF    = COORD_WIDTH / 2;
  localparam int OF    = OUT_WIDTH / 2;
  localparam int PW    = 2 * CW;
  localparam int DW    = 2 * CW + 3;
  localparam int NW    = 2 * CW + 1 + OF;
  localparam int CMPW  = DW + OW + 1;
  localparam int LastS = OW + 6;
  localparam int OutTW = ((9*OUT_WIDTH+7)/8)*8;
  localparam int NQ    = tsc_pkg::NumQuot;
  localparam int NC    = tsc_pkg::NumCorner;
  localparam int NX    = tsc_pkg::NumCoord;

  typedef struct packed {
    logic [NQ-1:0][NW-1:0] rem;
    logic [NQ-1:0][OW-1:0] quo;
    logic [NQ-1:0]         neg;
    logic [NQ-1:0]         ovf;
    logic [DW-1:0]         dm;
    logic                  degen;
    logic                  last;
  } div_t;

  logic [LastS:0] v_q;
  logic [LastS:0] adv;

  logic signed [CW-1:0]   crd_q [NX];
  logic                   last0_q;
  logic signed [PW-1:0]   prod_q [NX];
  logic signed [CW:0]     dif1_q [NX];
  logic                   last1_q;
  logic signed [PW:0]     cr2_q [NC];
  logic signed [CW:0]     dif2_q [NX];
  logic                   last2_q;
  logic signed [DW-1:0]   area3_q;
  logic signed [PW:0]     cr3_q [NC];
  logic signed [CW:0]     dif3_q [NX];
  logic                   degen3_q;
  logic                   last3_q;
  div_t                   mag_d, mag_q;
  div_t                   ovf_d;
  div_t                   div_q [OW+1];
  logic [OutTW-1:0]       out_d, out_q;
  logic                   degen_q, lasto_q;

  assign adv[LastS] = !v_q[LastS] || m_axis_tready;
  for (genvar k = 0; k < LastS; k++) begin : g_adv
    assign adv[k] = !v_q[k] || adv[k+1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (adv[0]) begin
        v_q[0] <= s_axis_tvalid;
      end
      for (int k = 1; k <= LastS; k++) begin
        if (adv[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  assign s_axis_tready = adv[0];

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      for (int f = 0; f < NX; f++) begin
        crd_q[f] <= s_axis_tdata[f*CW +: CW];
      end
      last0_q <= s_axis_tlast;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      for (int i = 0; i < NC; i++) begin
        prod_q[2*i]   <= crd_q[2*((i+1)%NC)] * crd_q[2*((i+2)%NC)+1];
        prod_q[2*i+1] <= crd_q[2*((i+2)%NC)] * crd_q[2*((i+1)%NC)+1];
        dif1_q[2*i]   <= (CW+1)'(crd_q[2*((i+1)%NC)+1]) - (CW+1)'(crd_q[2*((i+2)%NC)+1]);
        dif1_q[2*i+1] <= (CW+1)'(crd_q[2*((i+2)%NC)]) - (CW+1)'(crd_q[2*((i+1)%NC)]);
      end
      last1_q <= last0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[2]) begin
      for (int i = 0; i < NC; i++) begin
        cr2_q[i] <= (PW+1)'(prod_q[2*i]) - (PW+1)'(prod_q[2*i+1]);
      end
      dif2_q  <= dif1_q;
      last2_q <= last1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[3]) begin
      area3_q  <= DW'(cr2_q[0]) + DW'(cr2_q[1]) + DW'(cr2_q[2]);
      degen3_q <= (DW'(cr2_q[0]) + DW'(cr2_q[1]) + DW'(cr2_q[2])) == '0;
      cr3_q    <= cr2_q;
      dif3_q   <= dif2_q;
      last3_q  <= last2_q;
    end
  end

  always_comb begin
    logic [CW:0] dm_mag;
    logic [PW:0] cm_mag;
    mag_d = '0;
    mag_d.dm = area3_q[DW-1] ? DW'(-area3_q) : DW'(area3_q);
    for (int i = 0; i < NC; i++) begin
      for (int h = 0; h < 2; h++) begin
        dm_mag = dif3_q[2*i+h][CW] ? (CW+1)'(-dif3_q[2*i+h]) : (CW+1)'(dif3_q[2*i+h]);
        mag_d.rem[3*i+h] = NW'(dm_mag) << (CF + OF);
        mag_d.neg[3*i+h] = dif3_q[2*i+h][CW] ^ area3_q[DW-1];
      end
      cm_mag = cr3_q[i][PW] ? (PW+1)'(-cr3_q[i]) : (PW+1)'(cr3_q[i]);
      mag_d.rem[3*i+2] = NW'(cm_mag) << OF;
      mag_d.neg[3*i+2] = cr3_q[i][PW] ^ area3_q[DW-1];
    end
    mag_d.degen = degen3_q;
    mag_d.last  = last3_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv[4]) begin
      mag_q <= mag_d;
    end
  end

  always_comb begin
    ovf_d = mag_q;
    for (int k = 0; k < NQ; k++) begin
      ovf_d.ovf[k] = CMPW'(mag_q.rem[k]) >= (CMPW'(mag_q.dm) << OW);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[5]) begin
      div_q[0] <= ovf_d;
    end
  end

  for (genvar s = 1; s <= OW; s++) begin : g_div
    localparam int Bit = OW - s;
    div_t nx;
    always_comb begin
      logic [CMPW-1:0] shv;
      logic [CMPW:0]   diff;
      nx  = div_q[s-1];
      shv = CMPW'(div_q[s-1].dm) << Bit;
      for (int k = 0; k < NQ; k++) begin
        diff = {1'b0, CMPW'(div_q[s-1].rem[k])} - {1'b0, shv};
        if (!diff[CMPW]) begin
          nx.rem[k]      = diff[NW-1:0];
          nx.quo[k][Bit] = 1'b1;
        end
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv[5+s]) begin
        div_q[s] <= nx;
      end
    end
  end

  always_comb begin
    logic [OW-1:0] lim;
    logic [OW-1:0] sat;
    out_d = '0;
    for (int k = 0; k < NQ; k++) begin
      lim = div_q[OW].neg[k] ? (OW'(1) << (OW-1)) : ((OW'(1) << (OW-1)) - OW'(1));
      sat = (div_q[OW].ovf[k] || div_q[OW].quo[k] > lim) ? lim : div_q[OW].quo[k];
      if (div_q[OW].neg[k]) begin
        sat = -sat;
      end
      out_d[k*OW +: OW] = div_q[OW].degen ? '0 : sat;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[LastS]) begin
      out_q   <= out_d;
      degen_q <= div_q[OW].degen;
      lasto_q <= div_q[OW].last;
    end
  end

  assign m_axis_tvalid = v_q[LastS];
  assign m_axis_tdata  = out_q;
  assign m_axis_tuser  = degen_q;
  assign m_axis_tlast  = lasto_q;

endmodule

/* sv/tsc_checker.sv */
// Port-level checks of the triangle shape-function coefficient block.
// Depends on tsc_pkg; bound to triangle_shape_coeffs at the end of this file.
module tsc_port_checker #(
  parameter int COORD_WIDTH = 24,
  parameter int OUT_WIDTH   = 32
) (
  input logic clk_i,
  input logic rst_ni,
  input logic s_axis_tready,
  input logic m_axis_tvalid,
  input logic m_axis_tready,
  // a_one through c_three from the lowest bit up.
  input logic [((tsc_pkg::NumQuot*OUT_WIDTH+7)/8)*8-1:0] m_axis_tdata,
  // degenerate.
  input logic m_axis_tuser,
  input logic m_axis_tlast
);

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
    && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("Output word changed while stalled.");

  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
    else $error("Degenerate triangle gave nonzero coefficients.");

  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid)
    else $error("Output valid after reset.");

  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("Input stalled while the output stage is empty.");

endmodule

bind triangle_shape_coeffs tsc_port_checker #(
  .COORD_WIDTH(COORD_WIDTH),
  .OUT_WIDTH(OUT_WIDTH)
) u_tsc_checker (
  .clk_i(clk_i),
  .rst_ni(rst_ni),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata),
  .m_axis_tuser(m_axis_tuser),
  .m_axis_tlast(m_axis_tlast)
);
